### hw/rtl/btks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btks_pkg
// Shared types and sizes for the binary trie key set.
// ----------------------------------------------------------------------------
package btks_pkg;

    localparam int NODE_COUNT = 4096;
    localparam int KEY_BITS   = 32;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int CNT_BITS   = $clog2(NODE_COUNT + 1);
    localparam int LVL_BITS   = $clog2(KEY_BITS);

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic                action;
        logic [KEY_BITS-1:0] key_address;
    } req_t;

    typedef struct packed {
        logic found;
        logic status;
    } rsp_t;

endpackage

### hw/rtl/binary_trie_key_set_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_key_set_top
// Exact-match key set kept as a binary trie in an on-chip node pool.
//
// Request channel (req_valid / req_stall / req_data) carries an action
// (insert or search) and a 32-bit key. Each request yields exactly one
// response on rsp_valid / rsp_stall / rsp_data with found and status.
// From acceptance to the response register a request runs the walk (one
// node read and at most one node write per key bit, on a single read port
// and single write port of the node memory), then sets or reads the end
// mark, then loads the response. The root is read at the edge that takes
// the request. A search that misses early, or an insert that runs out of
// nodes, finishes sooner. req_stall is low only while no request is in
// flight, so requests are taken one at a time, each once the last has
// finished. A finished response waits in the output register; the
// next request is taken while it waits, and a further response waits until
// it drains. Reset empties the set at once: the node memory is never swept,
// since a node is initialized by the walk that allocates it, and what an
// unwritten node holds is never used. An insert that runs out of nodes
// reports status full.
// ----------------------------------------------------------------------------
module binary_trie_key_set_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  btks_pkg::req_t   req_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output btks_pkg::rsp_t   rsp_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    localparam logic [btks_pkg::LVL_BITS-1:0] LAST_LEVEL =
        btks_pkg::LVL_BITS'(btks_pkg::KEY_BITS - 1);
    localparam logic [btks_pkg::CNT_BITS-1:0] POOL_SIZE =
        btks_pkg::CNT_BITS'(btks_pkg::NODE_COUNT);
    localparam logic [btks_pkg::CNT_BITS-1:0] FIRST_FREE =
        btks_pkg::CNT_BITS'(1);

    logic [btks_pkg::NODE_BITS-1:0] zero_tab [btks_pkg::NODE_COUNT];
    logic [btks_pkg::NODE_BITS-1:0] one_tab  [btks_pkg::NODE_COUNT];
    logic                           end_tab  [btks_pkg::NODE_COUNT];

    logic [1:0]                     state_reg;
    logic                           action_reg;
    logic [btks_pkg::KEY_BITS-1:0]  key_reg;
    logic [btks_pkg::LVL_BITS-1:0]  level_reg;
    logic [btks_pkg::NODE_BITS-1:0] node_reg;
    logic                           fresh_reg;
    logic [btks_pkg::CNT_BITS-1:0]  next_free_reg;
    btks_pkg::rsp_t                 res_reg;
    logic                           rsp_valid_reg;
    btks_pkg::rsp_t                 rsp_data_reg;

    logic [btks_pkg::NODE_BITS-1:0] rd_zero_reg;
    logic [btks_pkg::NODE_BITS-1:0] rd_one_reg;
    logic                           rd_end_reg;

    logic                           bit_cur;
    logic [btks_pkg::NODE_BITS-1:0] child_raw;
    logic                           child_null;
    logic                           child_bad;
    logic                           pool_full;
    logic                           walk_end;
    logic [btks_pkg::NODE_BITS-1:0] child_node;
    logic [btks_pkg::NODE_BITS-1:0] rd_addr;
    logic                           we_zero;
    logic                           we_one;
    logic                           we_end;
    logic [btks_pkg::NODE_BITS-1:0] wd_zero;
    logic [btks_pkg::NODE_BITS-1:0] wd_one;
    logic                           wd_end;
    logic                           req_take;
    logic                           rsp_load;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && (state_reg == ST_IDLE);
    assign rsp_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // a fresh node has null links and no end mark, whatever the memory holds
    assign bit_cur    = key_reg[btks_pkg::KEY_BITS-1];
    assign child_raw  = fresh_reg ? '0 : (bit_cur ? rd_one_reg : rd_zero_reg);
    assign child_null = (child_raw == '0);
    assign child_bad  = (btks_pkg::CNT_BITS'(child_raw) >= POOL_SIZE);
    assign pool_full  = (next_free_reg >= POOL_SIZE);
    assign walk_end   = (action_reg == btks_pkg::ACT_INSERT)
                        ? ((child_null && pool_full) || (!child_null && child_bad))
                        : (child_null || child_bad);
    assign child_node = child_null ? btks_pkg::NODE_BITS'(next_free_reg) : child_raw;
    assign rd_addr    = (state_reg == ST_WALK) ? child_node : '0;

    always_comb
    begin
        we_zero = 1'b0;
        we_one  = 1'b0;
        we_end  = 1'b0;
        wd_zero = bit_cur ? '0 : child_node;
        wd_one  = bit_cur ? child_node : '0;
        wd_end  = 1'b0;
        if (state_reg == ST_WALK && action_reg == btks_pkg::ACT_INSERT && child_null)
        begin
            if (pool_full)
            begin
                wd_zero = '0;
                wd_one  = '0;
                we_zero = fresh_reg;
                we_one  = fresh_reg;
                we_end  = fresh_reg;
            end
            else
            begin
                we_zero = fresh_reg || !bit_cur;
                we_one  = fresh_reg || bit_cur;
                we_end  = fresh_reg;
            end
        end
        else if (state_reg == ST_FINISH && action_reg == btks_pkg::ACT_INSERT)
        begin
            wd_zero = '0;
            wd_one  = '0;
            wd_end  = 1'b1;
            we_zero = fresh_reg;
            we_one  = fresh_reg;
            we_end  = 1'b1;
        end
    end

    // node memory: one write at the current node, one read at the next node
    always_ff @(posedge clk)
    begin
        if (we_zero)
        begin
            zero_tab[node_reg] <= wd_zero;
        end
        if (we_one)
        begin
            one_tab[node_reg] <= wd_one;
        end
        if (we_end)
        begin
            end_tab[node_reg] <= wd_end;
        end
        rd_zero_reg <= zero_tab[rd_addr];
        rd_one_reg  <= one_tab[rd_addr];
        rd_end_reg  <= end_tab[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            action_reg    <= btks_pkg::ACT_INSERT;
            key_reg       <= '0;
            level_reg     <= '0;
            node_reg      <= '0;
            fresh_reg     <= 1'b0;
            next_free_reg <= FIRST_FREE;
            res_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && !rsp_load)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_take)
                    begin
                        action_reg <= req_data.action;
                        key_reg    <= req_data.key_address;
                        level_reg  <= '0;
                        node_reg   <= '0;
                        fresh_reg  <= (next_free_reg == FIRST_FREE);
                        state_reg  <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    key_reg   <= key_reg << 1;
                    level_reg <= level_reg + 1'b1;
                    if (level_reg == LAST_LEVEL && !walk_end)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    if (action_reg == btks_pkg::ACT_INSERT)
                    begin
                        if (child_null && pool_full)
                        begin
                            res_reg.found  <= 1'b0;
                            res_reg.status <= btks_pkg::STATUS_FULL;
                            state_reg      <= ST_DONE;
                        end
                        else if (child_null)
                        begin
                            next_free_reg <= next_free_reg + 1'b1;
                            node_reg      <= child_node;
                            fresh_reg     <= 1'b1;
                        end
                        else if (child_bad)
                        begin
                            res_reg.found  <= 1'b0;
                            res_reg.status <= btks_pkg::STATUS_FULL;
                            state_reg      <= ST_DONE;
                        end
                        else
                        begin
                            node_reg  <= child_raw;
                            fresh_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        if (child_null || child_bad)
                        begin
                            res_reg.found  <= 1'b0;
                            res_reg.status <= btks_pkg::STATUS_DONE;
                            state_reg      <= ST_DONE;
                        end
                        else
                        begin
                            node_reg  <= child_raw;
                            fresh_reg <= 1'b0;
                        end
                    end
                end
                ST_FINISH:
                begin
                    res_reg.found  <= (action_reg == btks_pkg::ACT_SEARCH)
                                      && !fresh_reg && rd_end_reg;
                    res_reg.status <= btks_pkg::STATUS_DONE;
                    state_reg      <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (rsp_load)
                    begin
                        rsp_data_reg  <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a fresh node is always the most recently allocated one
    assert property (@(posedge clk) disable iff (!rst_n)
        (fresh_reg && (state_reg == ST_WALK || state_reg == ST_FINISH))
        |-> (btks_pkg::CNT_BITS'(node_reg) == next_free_reg - 1'b1))
        else $error("fresh node is not the last allocated node");

    assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= POOL_SIZE)
        else $error("node pool counter overran the pool");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_WALK) |=> $stable(next_free_reg))
        else $error("node allocated outside the walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised without a finished request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && action_reg == btks_pkg::ACT_SEARCH)
        |-> !(we_zero || we_one || we_end))
        else $error("search wrote the node memory");

endmodule
